// ----- design/sslex_pkg.sv -----
`timescale 1ns / 1ps

package sslex_pkg;

  localparam int LINE_W = 16;
  localparam int COL_W  = 16;
  localparam int MAX_RES = 3;

  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_NUMBER      = 4'd1,
    MODE_IDENT       = 4'd2,
    MODE_STRING      = 4'd3,
    MODE_ESCAPE      = 4'd4,
    MODE_SLASH       = 4'd5,
    MODE_LINE_CMT    = 4'd6,
    MODE_BLOCK_CMT   = 4'd7,
    MODE_BLOCK_STAR  = 4'd8,
    MODE_SYMBOL      = 4'd9
  } mode_t;

  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_NUMBER  = 3'd1;
  localparam logic [2:0] KIND_IDENT   = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_BRACKET = 3'd4;
  localparam logic [2:0] KIND_SYMBOL  = 3'd5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_BSLSH = 8'h5c;

  // one result of the tokenizer
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] chr;
    logic       has;
    logic       tend;
  } res_t;

  // all results caused by one source byte, sharing the position counters
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MAX_RES-1:0]      res;
    logic [LINE_W-1:0]       line;
    logic [COL_W-1:0]        col;
  } grp_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c >= 8'd33 && c <= 8'd126 && !is_alnum(c);
  endfunction

  function automatic res_t mk_char(input logic [2:0] kind, input logic [7:0] c);
    res_t r;
    r.kind = kind;
    r.chr  = c;
    r.has  = 1'b1;
    r.tend = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_end(input logic [2:0] kind);
    res_t r;
    r.kind = kind;
    r.chr  = 8'h00;
    r.has  = 1'b0;
    r.tend = 1'b1;
    return r;
  endfunction

endpackage

// ----- design/script_source_lexer_core.sv -----
`timescale 1ns / 1ps

// streaming tokenizer for c-like script source
// input channel: one source byte per transfer (in_byte), or an end of input
// marker (in_end_of_input, or a zero byte) that closes any open token and
// then gives a kind-0 end-of-token result
// output channel: one result per transfer: a token character (has_char) or
// an end-of-token marker (token_end), with the line and column after the byte
// latency: the first result of a byte is valid the cycle after its transfer
// throughput: one byte per cycle while out_ready is high and each byte yields
// at most one result; a byte with several results holds the result register
// until all are taken, and in_ready returns in the cycle the last of them is taken
// bytes with no result (whitespace, comments) load nothing, but like any
// other byte they wait while an earlier group is still pending
// reset: lexer idle, line 1, column 0, no result pending
// a stalled receiver holds the current result steady; in_ready drops until
// the pending group drains, so no byte is lost

module script_source_lexer_core import sslex_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_token_kind,
  output logic [7:0]        out_char,
  output logic              out_has_char,
  output logic              out_token_end,
  output logic [LINE_W-1:0] out_line_number,
  output logic [COL_W-1:0]  out_column_number
);

  mode_t             mode_r, mode_nxt;
  logic              sq_r, sq_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  grp_t              grp;
  res_t              cur;
  logic              in_xfer;
  logic              free;

  assign in_ready = free;
  assign in_xfer  = in_valid && in_ready;

  sslex_step u_step (
    .mode     (mode_r),
    .sq       (sq_r),
    .line     (line_r),
    .col      (col_r),
    .in_byte  (in_byte),
    .in_eoi   (in_end_of_input),
    .mode_nxt (mode_nxt),
    .sq_nxt   (sq_nxt),
    .line_nxt (line_nxt),
    .col_nxt  (col_nxt),
    .grp      (grp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      sq_r   <= 1'b0;
      line_r <= LINE_W'(1);
      col_r  <= '0;
    end else if (in_xfer) begin
      mode_r <= mode_nxt;
      sq_r   <= sq_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  sslex_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer && (grp.cnt != 2'd0)),
    .grp       (grp),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .cur       (cur),
    .cur_line  (out_line_number),
    .cur_col   (out_column_number)
  );

  assign out_token_kind = cur.kind;
  assign out_char       = cur.chr;
  assign out_has_char   = cur.has;
  assign out_token_end  = cur.tend;

endmodule

// ----- design/sslex_step.sv -----
`timescale 1ns / 1ps

module sslex_step import sslex_pkg::*; (
  input  mode_t             mode,
  input  logic              sq,
  input  logic [LINE_W-1:0] line,
  input  logic [COL_W-1:0]  col,
  input  logic [7:0]        in_byte,
  input  logic              in_eoi,
  output mode_t             mode_nxt,
  output logic              sq_nxt,
  output logic [LINE_W-1:0] line_nxt,
  output logic [COL_W-1:0]  col_nxt,
  output grp_t              grp
);

  logic              eoi;
  mode_t             st_mode;
  logic              st_sq_we;
  logic              st_sq;
  logic [1:0]        st_n;
  res_t [1:0]        st_r;
  logic [1:0]        n;
  res_t [MAX_RES-1:0] res;
  logic [7:0]        c;

  assign c   = in_byte;
  assign eoi = in_eoi || (c == 8'h00);

  // what the byte does when it opens a token
  always_comb begin
    st_mode  = MODE_IDLE;
    st_sq_we = 1'b0;
    st_sq    = 1'b0;
    st_n     = 2'd0;
    st_r     = '0;
    if (is_space(c)) begin
      st_mode = MODE_IDLE;
    end else if (is_digit(c)) begin
      st_mode = MODE_NUMBER;
      st_r[0] = mk_char(KIND_NUMBER, c);
      st_n    = 2'd1;
    end else if (is_alpha(c) || c == "_") begin
      st_mode = MODE_IDENT;
      st_r[0] = mk_char(KIND_IDENT, c);
      st_n    = 2'd1;
    end else if (c == CH_SQUOT || c == CH_DQUOT) begin
      st_mode  = MODE_STRING;
      st_sq_we = 1'b1;
      st_sq    = (c == CH_SQUOT);
    end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}") begin
      st_r[0] = mk_char(KIND_BRACKET, c);
      st_r[1] = mk_end(KIND_BRACKET);
      st_n    = 2'd2;
    end else if (c == "/") begin
      st_mode = MODE_SLASH;
    end else if (is_punct(c)) begin
      st_mode = MODE_SYMBOL;
      st_r[0] = mk_char(KIND_SYMBOL, c);
      st_n    = 2'd1;
    end
  end

  always_comb begin
    mode_nxt = mode;
    sq_nxt   = sq;
    line_nxt = line;
    col_nxt  = col;
    n        = 2'd0;
    res      = '0;
    if (eoi) begin
      case (mode)
        MODE_NUMBER: begin
          res[n] = mk_end(KIND_NUMBER); n = n + 2'd1;
        end
        MODE_IDENT: begin
          res[n] = mk_end(KIND_IDENT); n = n + 2'd1;
        end
        MODE_STRING, MODE_ESCAPE: begin
          res[n] = mk_end(KIND_STRING); n = n + 2'd1;
        end
        MODE_SYMBOL: begin
          res[n] = mk_end(KIND_SYMBOL); n = n + 2'd1;
        end
        MODE_SLASH: begin
          res[n] = mk_char(KIND_SYMBOL, "/"); n = n + 2'd1;
          res[n] = mk_end(KIND_SYMBOL); n = n + 2'd1;
        end
        default: begin
        end
      endcase
      res[n] = mk_end(KIND_END); n = n + 2'd1;
      mode_nxt = MODE_IDLE;
    end else begin
      if (c == CH_NL) begin
        if (line != '1) line_nxt = line + 1'b1;
        col_nxt = COL_W'(1);
      end else if (col != '1) begin
        col_nxt = col + 1'b1;
      end
      case (mode)
        MODE_NUMBER: begin
          if (is_alnum(c) || c == ".") begin
            res[n] = mk_char(KIND_NUMBER, c); n = n + 2'd1;
          end else begin
            res[n] = mk_end(KIND_NUMBER); n = n + 2'd1;
            mode_nxt = st_mode;
            if (st_sq_we) sq_nxt = st_sq;
            for (int i = 0; i < 2; i++) begin
              if (2'(i) < st_n) begin
                res[n] = st_r[i]; n = n + 2'd1;
              end
            end
          end
        end
        MODE_IDENT: begin
          if (is_alnum(c) || c == "_") begin
            res[n] = mk_char(KIND_IDENT, c); n = n + 2'd1;
          end else begin
            res[n] = mk_end(KIND_IDENT); n = n + 2'd1;
            mode_nxt = st_mode;
            if (st_sq_we) sq_nxt = st_sq;
            for (int i = 0; i < 2; i++) begin
              if (2'(i) < st_n) begin
                res[n] = st_r[i]; n = n + 2'd1;
              end
            end
          end
        end
        MODE_STRING: begin
          if (c == (sq ? CH_SQUOT : CH_DQUOT)) begin
            res[n] = mk_end(KIND_STRING); n = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end else if (c == CH_BSLSH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            res[n] = mk_char(KIND_STRING, c); n = n + 2'd1;
          end
        end
        MODE_ESCAPE: begin
          mode_nxt = MODE_STRING;
          case (c)
            "t": begin res[n] = mk_char(KIND_STRING, CH_TAB); n = n + 2'd1; end
            "b": begin res[n] = mk_char(KIND_STRING, CH_BS);  n = n + 2'd1; end
            "n": begin res[n] = mk_char(KIND_STRING, CH_NL);  n = n + 2'd1; end
            "r": begin res[n] = mk_char(KIND_STRING, CH_CR);  n = n + 2'd1; end
            "f": begin res[n] = mk_char(KIND_STRING, CH_FF);  n = n + 2'd1; end
            CH_SQUOT, CH_DQUOT, CH_BSLSH: begin
              res[n] = mk_char(KIND_STRING, c); n = n + 2'd1;
            end
            default: begin
            end
          endcase
        end
        MODE_SLASH, MODE_SYMBOL: begin
          if (mode == MODE_SLASH && c == "/") begin
            mode_nxt = MODE_LINE_CMT;
          end else if (mode == MODE_SLASH && c == "*") begin
            mode_nxt = MODE_BLOCK_CMT;
          end else begin
            // a lone slash becomes the first character of a symbol
            if (mode == MODE_SLASH) begin
              res[n] = mk_char(KIND_SYMBOL, "/"); n = n + 2'd1;
            end
            if (is_punct(c)) begin
              mode_nxt = MODE_SYMBOL;
              res[n] = mk_char(KIND_SYMBOL, c); n = n + 2'd1;
            end else begin
              res[n] = mk_end(KIND_SYMBOL); n = n + 2'd1;
              mode_nxt = st_mode;
              if (st_sq_we) sq_nxt = st_sq;
              for (int i = 0; i < 2; i++) begin
                if (2'(i) < st_n) begin
                  res[n] = st_r[i]; n = n + 2'd1;
                end
              end
            end
          end
        end
        MODE_LINE_CMT: begin
          if (c == CH_NL) mode_nxt = MODE_IDLE;
        end
        MODE_BLOCK_CMT: begin
          if (c == "*") mode_nxt = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (c == "/") mode_nxt = MODE_IDLE;
          else if (c != "*") mode_nxt = MODE_BLOCK_CMT;
        end
        default: begin
          mode_nxt = st_mode;
          if (st_sq_we) sq_nxt = st_sq;
          for (int i = 0; i < 2; i++) begin
            if (2'(i) < st_n) begin
              res[n] = st_r[i]; n = n + 2'd1;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    grp.cnt  = n;
    grp.res  = res;
    grp.line = line_nxt;
    grp.col  = col_nxt;
  end

endmodule

// ----- design/sslex_queue.sv -----
`timescale 1ns / 1ps

module sslex_queue import sslex_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  grp_t              grp,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              free,
  output res_t              cur,
  output logic [LINE_W-1:0] cur_line,
  output logic [COL_W-1:0]  cur_col
);

  grp_t       grp_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       last;
  logic       out_xfer;

  assign last      = (idx_r == grp_r.cnt - 2'd1);
  assign out_xfer  = valid_r && out_ready;
  assign free      = !valid_r || (out_ready && last);
  assign out_valid = valid_r;
  assign cur       = grp_r.res[idx_r];
  assign cur_line  = grp_r.line;
  assign cur_col   = grp_r.col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (out_xfer) begin
      if (last) valid_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp_r <= grp;
  end

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r < grp_r.cnt))
    else $error("result index beyond group count");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("group overwritten before it drained");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (grp.cnt != 2'd0))
    else $error("empty group loaded");

  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && last && !load) |=> !valid_r)
    else $error("output still valid after last transfer");
`endif

endmodule
